/* design/qmop_pkg.sv */
// shared constants, types and helpers of the quadratic map orbit projector
package qmop_pkg;

   localparam int COORD_WIDTH_DEF     = 32;
   localparam int COORD_FRAC_BITS_DEF = 24;
   localparam int COEFF_COUNT         = 18;
   localparam int TERM_COUNT          = COEFF_COUNT / 2;

   localparam int T_WIDTH      = 32;
   localparam int T_FRAC_BITS  = 24;
   localparam int SCREEN_WIDTH = 24;
   localparam int CSR_WIDTH    = 36;
   localparam int CSR_IDX_BITS = 3;
   localparam int SCALE_BITS   = 16;
   localparam int WIN_BITS     = 13;
   localparam int CNT_BITS     = 12;
   localparam int SCALE_H_BITS = SCALE_BITS + WIN_BITS - 1;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_COEFF    = 3'd0,
      CSR_SCALE    = 3'd1,
      CSR_CENTER_X = 3'd2,
      CSR_CENTER_Y = 3'd3,
      CSR_WIN_W    = 3'd4,
      CSR_WIN_H    = 3'd5,
      CSR_ORBIT    = 3'd6,
      CSR_WARMUP   = 3'd7
   } csr_index_type;

   localparam logic [1:0] CODE_PLUS  = 2'd1;
   localparam logic [1:0] CODE_MINUS = 2'd2;

   localparam logic [CSR_WIDTH-1:0]  RST_COEFF  = 36'd9305073153;
   localparam logic [SCALE_BITS-1:0] RST_SCALE  = 16'd1024;
   localparam logic [WIN_BITS-1:0]   RST_WIN_W  = 13'd1600;
   localparam logic [WIN_BITS-1:0]   RST_WIN_H  = 13'd900;
   localparam logic [CNT_BITS-1:0]   RST_ORBIT  = 12'd800;
   localparam logic [CNT_BITS-1:0]   RST_WARMUP = 12'd100;

   typedef struct packed {
      logic [CSR_WIDTH-1:0]    coeff;
      logic [SCALE_H_BITS-1:0] scale_h;
      logic [T_WIDTH-1:0]      center_x;
      logic [T_WIDTH-1:0]      center_y;
      logic [WIN_BITS-1:0]     win_w;
      logic [WIN_BITS-1:0]     win_h;
      logic [CNT_BITS-1:0]     orbit_len;
      logic [CNT_BITS-1:0]     warmup;
   } cfg_type;

   // alignment shift of a q8.24 value into the coordinate format
   function automatic int align_shl(input int frac_bits);
      return (frac_bits >= T_FRAC_BITS) ? frac_bits - T_FRAC_BITS : 0;
   endfunction

   function automatic int align_shr(input int frac_bits);
      return (frac_bits < T_FRAC_BITS) ? T_FRAC_BITS - frac_bits : 0;
   endfunction

endpackage

/* design/qmop_if.sv */
// request and response channel interfaces
interface qmop_req_if;
   logic                             valid;
   logic                             ready;
   logic signed [qmop_pkg::T_WIDTH-1:0] orbit_t;
   modport source (output valid, output orbit_t, input ready);
   modport sink (input valid, input orbit_t, output ready);
endinterface

interface qmop_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [qmop_pkg::SCREEN_WIDTH-1:0] screen_x;
   logic signed [qmop_pkg::SCREEN_WIDTH-1:0] screen_y;
   logic                                  hidden;
   logic                                  saturated;
   logic                                  orbit_last;
   modport source (output valid, output screen_x, output screen_y, output hidden,
                   output saturated, output orbit_last, input ready);
   modport sink (input valid, input screen_x, input screen_y, input hidden,
                 input saturated, input orbit_last, output ready);
endinterface

/* design/qmop_front.sv */
// front end: takes requests and aligns t to the coordinate format with clipping
module qmop_front #(
   parameter int COORD_WIDTH     = qmop_pkg::COORD_WIDTH_DEF,
   parameter int COORD_FRAC_BITS = qmop_pkg::COORD_FRAC_BITS_DEF
) (
   input  logic                   q_full,
   qmop_req_if.sink               req_chan,
   output logic                   q_push,
   output logic [COORD_WIDTH-1:0] q_t,
   output logic                   q_tsat
);
   import qmop_pkg::*;

   localparam int SHL = align_shl(COORD_FRAC_BITS);
   localparam int SHR = align_shr(COORD_FRAC_BITS);
   localparam int AL  = T_WIDTH + SHL + 1 > COORD_WIDTH + 1 ? T_WIDTH + SHL + 1 : COORD_WIDTH + 1;

   logic signed [AL-1:0] aligned;
   logic                 fits;

   assign req_chan.ready = !q_full;
   assign q_push         = req_chan.valid && !q_full;

   always_comb begin
      aligned = ($signed({{(AL-T_WIDTH){req_chan.orbit_t[T_WIDTH-1]}}, req_chan.orbit_t})
                 <<< SHL) >>> SHR;
      fits    = (&aligned[AL-1:COORD_WIDTH-1]) || !(|aligned[AL-1:COORD_WIDTH-1]);
      q_tsat  = !fits;
      if (fits) begin
         q_t = aligned[COORD_WIDTH-1:0];
      end else begin
         q_t = {aligned[AL-1], {(COORD_WIDTH-1){!aligned[AL-1]}}};
      end
   end
endmodule

/* design/qmop_queue.sv */
// two-entry request queue between front and back
module qmop_queue #(
   parameter int WIDTH = qmop_pkg::COORD_WIDTH_DEF + 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             full,
   output logic             not_empty,
   output logic [WIDTH-1:0] head
);
   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = count_ff == 2'd2;
   assign not_empty = count_ff != 2'd0;
   assign head      = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

/* design/qmop_back.sv */
// back end: map iteration and projection on one shared multiplier, output register
module qmop_back #(
   parameter int COORD_WIDTH     = qmop_pkg::COORD_WIDTH_DEF,
   parameter int COORD_FRAC_BITS = qmop_pkg::COORD_FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  qmop_pkg::cfg_type      cfg,
   input  logic                   q_valid,
   input  logic [COORD_WIDTH-1:0] q_t,
   input  logic                   q_tsat,
   output logic                   q_pop,
   qmop_rsp_if.source             rsp_chan
);
   import qmop_pkg::*;

   localparam int SHL = align_shl(COORD_FRAC_BITS);
   localparam int SHR = align_shr(COORD_FRAC_BITS);
   localparam int DW  = (COORD_WIDTH > T_WIDTH + SHL ? COORD_WIDTH : T_WIDTH + SHL) + 1;
   localparam int PW  = 2 * DW;
   localparam int AW  = PW - COORD_FRAC_BITS + 4;
   localparam int CW  = COORD_WIDTH;
   localparam int PSH = COORD_FRAC_BITS + 4;

   localparam logic [3:0] STEP_LIN    = 4'd7;
   localparam logic [3:0] STEP_PROJ_X = 4'd8;
   localparam logic [3:0] STEP_PROJ_Y = 4'd9;
   localparam logic [3:0] STEP_DONE   = 4'd10;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_RUN  = 2'b10
   } state_type;

   state_type            state_ff, state_in;
   logic [3:0]           step_ff, step_in;
   logic [CW-1:0]        t_ff, x_ff, y_ff;
   logic signed [AW-1:0] accx_ff, accy_ff;
   logic signed [PW-1:0] prod_ff;
   logic                 flag_ff;
   logic [CNT_BITS-1:0]  idx_ff, idx_in;
   logic [SCREEN_WIDTH-1:0] sx_ff;
   logic                 out_valid_ff;
   logic [SCREEN_WIDTH-1:0] out_x_ff, out_y_ff;
   logic                 out_hid_ff, out_sat_ff, out_last_ff;

   logic signed [DW-1:0] op_a, op_b;
   logic signed [DW-1:0] cxa, cya, dx, dy, s_op;
   logic signed [AW-1:0] term, nx, ny;
   logic [1:0]           code_x, code_y;
   logic [3:0]           tsel;
   logic                 x_fits, y_fits;
   logic signed [PW-1:0] q_proj;
   logic                 p_fits;
   logic [SCREEN_WIDTH-1:0] p_val;
   logic [WIN_BITS-1:0]  p_size;
   logic [WIN_BITS:0]    len, idx_next;
   logic                 last, finish, out_free;

   function automatic logic signed [AW-1:0] add_coded(input logic signed [AW-1:0] acc,
                                                      input logic signed [AW-1:0] val,
                                                      input logic [1:0] code);
      logic signed [AW-1:0] r;
      case (code)
         CODE_PLUS:  r = acc + val;
         CODE_MINUS: r = acc - val;
         default:    r = acc;
      endcase
      return r;
   endfunction

   function automatic logic signed [AW-1:0] sx_coord(input logic [CW-1:0] v);
      return $signed({{(AW-CW){v[CW-1]}}, v});
   endfunction

   function automatic logic signed [DW-1:0] ext_d(input logic [CW-1:0] v);
      return $signed({{(DW-CW){v[CW-1]}}, v});
   endfunction

   // view centers aligned to the coordinate format
   assign cxa  = ($signed({{(DW-T_WIDTH){cfg.center_x[T_WIDTH-1]}}, cfg.center_x}) <<< SHL)
                 >>> SHR;
   assign cya  = ($signed({{(DW-T_WIDTH){cfg.center_y[T_WIDTH-1]}}, cfg.center_y}) <<< SHL)
                 >>> SHR;
   assign dx   = ext_d(x_ff) - cxa;
   assign dy   = ext_d(y_ff) - cya;
   assign s_op = $signed({{(DW-SCALE_H_BITS){1'b0}}, cfg.scale_h});

   // operand select of the shared multiplier
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (step_ff)
         4'd0:        begin op_a = ext_d(x_ff); op_b = ext_d(x_ff); end
         4'd1:        begin op_a = ext_d(y_ff); op_b = ext_d(y_ff); end
         4'd2:        begin op_a = ext_d(t_ff); op_b = ext_d(t_ff); end
         4'd3:        begin op_a = ext_d(x_ff); op_b = ext_d(y_ff); end
         4'd4:        begin op_a = ext_d(x_ff); op_b = ext_d(t_ff); end
         4'd5:        begin op_a = ext_d(y_ff); op_b = ext_d(t_ff); end
         STEP_PROJ_X: begin op_a = dx; op_b = s_op; end
         STEP_PROJ_Y: begin op_a = dy; op_b = s_op; end
         default:     begin op_a = '0; op_b = '0; end
      endcase
   end

   // product term of the previous step, floored
   always_comb begin
      tsel   = step_ff - 4'd1;
      term   = AW'(prod_ff >>> COORD_FRAC_BITS);
      code_x = cfg.coeff[2*tsel +: 2];
      code_y = cfg.coeff[2*(tsel + 4'd9) +: 2];
   end

   // linear terms and clipping of the new point
   always_comb begin
      nx = add_coded(accx_ff, sx_coord(x_ff), cfg.coeff[13:12]);
      nx = add_coded(nx, sx_coord(y_ff), cfg.coeff[15:14]);
      nx = add_coded(nx, sx_coord(t_ff), cfg.coeff[17:16]);
      ny = add_coded(accy_ff, sx_coord(x_ff), cfg.coeff[31:30]);
      ny = add_coded(ny, sx_coord(y_ff), cfg.coeff[33:32]);
      ny = add_coded(ny, sx_coord(t_ff), cfg.coeff[35:34]);
      x_fits = (&nx[AW-1:CW-1]) || !(|nx[AW-1:CW-1]);
      y_fits = (&ny[AW-1:CW-1]) || !(|ny[AW-1:CW-1]);
   end

   // projection result from the registered product
   always_comb begin
      p_size = (step_ff == STEP_PROJ_Y) ? cfg.win_w : cfg.win_h;
      q_proj = (prod_ff >>> PSH) + $signed({{(PW-WIN_BITS-7){1'b0}}, p_size, 7'd0});
      p_fits = (&q_proj[PW-1:SCREEN_WIDTH-1]) || !(|q_proj[PW-1:SCREEN_WIDTH-1]);
      p_val  = p_fits ? q_proj[SCREEN_WIDTH-1:0]
                      : {q_proj[PW-1], {(SCREEN_WIDTH-1){!q_proj[PW-1]}}};
   end

   // orbit bookkeeping
   always_comb begin
      len      = (cfg.orbit_len == '0) ? {1'b1, {CNT_BITS{1'b0}}} : {1'b0, cfg.orbit_len};
      idx_next = {1'b0, idx_ff} + 1'b1;
      last     = idx_next >= len;
   end

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign finish   = (state_ff == S_RUN) && (step_ff == STEP_DONE) && out_free;
   assign q_pop    = (state_ff == S_IDLE) && q_valid;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      idx_in   = idx_ff;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               state_in = S_RUN;
               step_in  = 4'd0;
            end
         end
         S_RUN: begin
            if (step_ff != STEP_DONE) begin
               step_in = step_ff + 4'd1;
            end else if (out_free) begin
               state_in = S_IDLE;
               idx_in   = last ? '0 : idx_next[CNT_BITS-1:0];
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= 4'd0;
         idx_ff       <= '0;
         x_ff         <= '0;
         y_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         idx_ff   <= idx_in;
         if (q_pop && idx_ff == '0) begin
            x_ff <= q_t;
            y_ff <= q_t;
         end else if (state_ff == S_RUN && step_ff == STEP_LIN) begin
            x_ff <= x_fits ? nx[CW-1:0] : {nx[AW-1], {(CW-1){!nx[AW-1]}}};
            y_ff <= y_fits ? ny[CW-1:0] : {ny[AW-1], {(CW-1){!ny[AW-1]}}};
         end
         if (finish) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         t_ff    <= q_t;
         flag_ff <= q_tsat;
         accx_ff <= '0;
         accy_ff <= '0;
      end else if (state_ff == S_RUN) begin
         if (step_ff <= 4'd5 || step_ff == STEP_PROJ_X || step_ff == STEP_PROJ_Y) begin
            prod_ff <= op_a * op_b;
         end
         if (step_ff >= 4'd1 && step_ff <= 4'd6) begin
            accx_ff <= add_coded(accx_ff, term, code_x);
            accy_ff <= add_coded(accy_ff, term, code_y);
         end
         if (step_ff == STEP_LIN) begin
            flag_ff <= flag_ff || !x_fits || !y_fits;
         end
         if (step_ff == STEP_PROJ_Y) begin
            sx_ff   <= p_val;
            flag_ff <= flag_ff || !p_fits;
         end
      end
      if (finish) begin
         out_x_ff    <= sx_ff;
         out_y_ff    <= p_val;
         out_sat_ff  <= flag_ff || !p_fits;
         out_hid_ff  <= idx_ff < cfg.warmup;
         out_last_ff <= last;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.screen_x   = out_x_ff;
   assign rsp_chan.screen_y   = out_y_ff;
   assign rsp_chan.hidden     = out_hid_ff;
   assign rsp_chan.saturated  = out_sat_ff;
   assign rsp_chan.orbit_last = out_last_ff;
endmodule

/* design/quadratic_map_orbit_projector_top.sv */
// top level of the quadratic map orbit projector
// Each request carries the orbit parameter t (signed q8.24) and yields exactly one
// response: the next point of a quadratic map with 18 ternary coefficients,
// projected to screen pixels in signed q16.8, with hidden, saturated and
// orbit_last flags. The point restarts from x = y = t at the first iteration of
// every orbit. From the queue head a request is taken from the queue, then goes
// through the six map products on the one shared multiplier, folding in the
// last product, linear terms and clipping, the two projection products and
// finishing the y projection, which waits while the result register is held.
// The engine takes a new request only after it has finished the last one.
// A two-entry queue in front and the result register at the back let requests
// be taken while a result waits. Configuration writes take effect at once and
// are meant for idle periods; the zoom times half window height product is
// registered, so let it load after a write before the next request.
module quadratic_map_orbit_projector_top #(
   parameter int COORD_WIDTH     = qmop_pkg::COORD_WIDTH_DEF,
   parameter int COORD_FRAC_BITS = qmop_pkg::COORD_FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   qmop_req_if.sink                          req_chan,
   qmop_rsp_if.source                        rsp_chan,
   input  logic                              csr_write_enable,
   input  logic [qmop_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [qmop_pkg::CSR_WIDTH-1:0]    csr_write_data
);
   import qmop_pkg::*;

   // configuration registers
   logic [CSR_WIDTH-1:0]    coeff_ff;
   logic [SCALE_BITS-1:0]   scale_ff;
   logic [T_WIDTH-1:0]      cx_ff, cy_ff;
   logic [WIN_BITS-1:0]     win_w_ff, win_h_ff;
   logic [CNT_BITS-1:0]     orbit_ff, warmup_ff;
   logic [SCALE_H_BITS-1:0] scale_h_ff;
   cfg_type                 cfg;

   // front to queue to back
   logic                    q_full, q_push, q_tsat, q_pop, q_valid;
   logic [COORD_WIDTH-1:0]  q_t;
   logic [COORD_WIDTH:0]    q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff  <= RST_COEFF;
         scale_ff  <= RST_SCALE;
         cx_ff     <= '0;
         cy_ff     <= '0;
         win_w_ff  <= RST_WIN_W;
         win_h_ff  <= RST_WIN_H;
         orbit_ff  <= RST_ORBIT;
         warmup_ff <= RST_WARMUP;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_COEFF:    coeff_ff  <= csr_write_data;
            CSR_SCALE:    scale_ff  <= csr_write_data[SCALE_BITS-1:0];
            CSR_CENTER_X: cx_ff     <= csr_write_data[T_WIDTH-1:0];
            CSR_CENTER_Y: cy_ff     <= csr_write_data[T_WIDTH-1:0];
            CSR_WIN_W:    win_w_ff  <= csr_write_data[WIN_BITS-1:0];
            CSR_WIN_H:    win_h_ff  <= csr_write_data[WIN_BITS-1:0];
            CSR_ORBIT:    orbit_ff  <= csr_write_data[CNT_BITS-1:0];
            CSR_WARMUP:   warmup_ff <= csr_write_data[CNT_BITS-1:0];
            default:      ;
         endcase
      end
   end

   // zoom times floor of half window height, registered from the scale and window height registers
   always_ff @(posedge clock) begin
      scale_h_ff <= scale_ff * win_h_ff[WIN_BITS-1:1];
   end

   always_comb begin
      cfg.coeff     = coeff_ff;
      cfg.scale_h   = scale_h_ff;
      cfg.center_x  = cx_ff;
      cfg.center_y  = cy_ff;
      cfg.win_w     = win_w_ff;
      cfg.win_h     = win_h_ff;
      cfg.orbit_len = orbit_ff;
      cfg.warmup    = warmup_ff;
   end

   // front: request intake and t alignment
   qmop_front #(
      .COORD_WIDTH     (COORD_WIDTH),
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_front (
      .q_full   (q_full),
      .req_chan (req_chan),
      .q_push   (q_push),
      .q_t      (q_t),
      .q_tsat   (q_tsat)
   );

   // queue decouples intake from the iteration engine
   qmop_queue #(
      .WIDTH (COORD_WIDTH + 1)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({q_tsat, q_t}),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_valid),
      .head      (q_head)
   );

   // back: map step, projection and result register
   qmop_back #(
      .COORD_WIDTH     (COORD_WIDTH),
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .q_valid  (q_valid),
      .q_t      (q_head[COORD_WIDTH-1:0]),
      .q_tsat   (q_head[COORD_WIDTH]),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );
endmodule

/* design/qmop_checker.sv */
// port-level checker of the orbit projector and its bind
module qmop_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [qmop_pkg::SCREEN_WIDTH-1:0] rsp_screen_x,
   input logic [qmop_pkg::SCREEN_WIDTH-1:0] rsp_screen_y
);
   logic [2:0] open_ff;
   logic       req_fire, rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 3'd0;
      end else begin
         open_ff <= open_ff + {2'd0, req_fire} - {2'd0, rsp_fire};
      end
   end

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> open_ff != 3'd0)
      else $error("response without an open request");
   a_open_bound: assert property (@(posedge clock) disable iff (reset)
      open_ff <= 3'd4)
      else $error("more requests in flight than the design holds");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_screen_x) && $stable(rsp_screen_y))
      else $error("stalled response changed");
endmodule

bind quadratic_map_orbit_projector_top qmop_checker u_qmop_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_screen_x (rsp_chan.screen_x),
   .rsp_screen_y (rsp_chan.screen_y)
);
